[rtl/potq_pkg.sv]
// ----------------------------------------------------------------------------
// potq_pkg
// shared types, codes and default sizes of the priority ordered task queue
// ----------------------------------------------------------------------------
`default_nettype none

package potq_pkg;

  // field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned TID_W    = 8;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // default sizes
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned ID_BITS_DEF = 8;

  // request codes
  localparam logic [FUNC_W-1:0] FN_ENQ = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REM = 2'd1;
  localparam logic [FUNC_W-1:0] FN_POP = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // action broadcast to every cell
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INS,
    ACT_DEL,
    ACT_POP
  } act_e;

  typedef struct packed {
    act_e              act;
    logic [PRIO_W-1:0] prio;
  } ctrl_t;

endpackage

`default_nettype wire

[rtl/potq_cell.sv]
// ----------------------------------------------------------------------------
// potq_cell
// one slot of the sorted row: compares against the request, shifts with
// its neighbours
// ----------------------------------------------------------------------------
`default_nettype none

module potq_cell #(
  parameter int unsigned ID_BITS = potq_pkg::ID_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire potq_pkg::ctrl_t         ctrl_i,
  input  wire [ID_BITS-1:0]            req_id_i,
  // left neighbour (towards the front)
  input  wire                          left_ge_i,
  input  wire                          left_vld_i,
  input  wire [ID_BITS-1:0]            left_id_i,
  input  wire [potq_pkg::PRIO_W-1:0]   left_prio_i,
  // right neighbour (towards the back)
  input  wire                          right_vld_i,
  input  wire [ID_BITS-1:0]            right_id_i,
  input  wire [potq_pkg::PRIO_W-1:0]   right_prio_i,
  // match seen in a slot before this one
  input  wire                          seen_i,
  output logic                         vld_o,
  output logic [ID_BITS-1:0]           id_o,
  output logic [potq_pkg::PRIO_W-1:0]  prio_o,
  output logic                         ge_o,
  output logic                         seen_o
);
  import potq_pkg::*;

  logic              vld_q, vld_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic              hit;

  // empty slots count as greater, so an entry with no greater priority goes to the first empty one
  assign ge_o   = !vld_q || (prio_q > ctrl_i.prio);
  assign hit    = vld_q && (id_q == req_id_i);
  assign seen_o = seen_i || hit;

  always_comb begin
    vld_d  = vld_q;
    id_d   = id_q;
    prio_d = prio_q;
    case (ctrl_i.act)
      ACT_INS: begin
        if (left_ge_i) begin
          vld_d  = left_vld_i;
          id_d   = left_id_i;
          prio_d = left_prio_i;
        end else if (ge_o) begin
          vld_d  = 1'b1;
          id_d   = req_id_i;
          prio_d = ctrl_i.prio;
        end
      end
      ACT_DEL: begin
        if (seen_o) begin
          vld_d  = right_vld_i;
          id_d   = right_id_i;
          prio_d = right_prio_i;
        end
      end
      ACT_POP: begin
        vld_d  = right_vld_i;
        id_d   = right_id_i;
        prio_d = right_prio_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign vld_o  = vld_q;
  assign id_o   = id_q;
  assign prio_o = prio_q;

endmodule

`default_nettype wire

[rtl/priority_ordered_task_queue_top.sv]
// ----------------------------------------------------------------------------
// priority_ordered_task_queue_top
// task queue kept sorted by ascending priority in a row of slot cells
// a request is registered with busy high; the row compares and shifts and
//   the result is registered with done_o high, taken at the edge that ends it
// a new request is not taken while busy is high; busy is high for the cycle
//   in which the row of cells compares and shifts in one go
// reset: entry count and slot valid bits clear at once, no clearing pass
// results cannot be stalled: each is shown for one cycle only
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ordered_task_queue_top #(
  parameter int unsigned DEPTH   = potq_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS = potq_pkg::ID_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // request side
  input  wire                            start,
  output logic                           busy,
  input  wire [potq_pkg::FUNC_W-1:0]     func_i,
  input  wire [potq_pkg::TID_W-1:0]      task_id_i,
  input  wire [potq_pkg::PRIO_W-1:0]     priority_req_i,
  // result side
  output logic                           done_o,
  output logic [potq_pkg::STATUS_W-1:0]  status_o,
  output logic [potq_pkg::TID_W-1:0]     out_task_id_o,
  output logic [potq_pkg::PRIO_W-1:0]    out_priority_o,
  output logic [potq_pkg::OCC_W-1:0]     occupancy_o
);
  import potq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // request register
  logic                 accept;
  logic                 pend_q;
  logic [FUNC_W-1:0]    func_q;
  logic [ID_BITS-1:0]   req_id_q;
  logic [PRIO_W-1:0]    req_prio_q;
  logic [ID_BITS+TID_W-1:0] id_in_ext;

  // occupancy
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W+OCC_W-1:0] count_ext;

  // result register
  logic                 done_q;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [TID_W-1:0]     oid_q, oid_d;
  logic [PRIO_W-1:0]    oprio_q, oprio_d;
  logic [OCC_W-1:0]     occ_q;
  logic [ID_BITS+TID_W-1:0] id_out_ext;

  // the row
  ctrl_t                ctrl;
  act_e                 act;
  logic [DEPTH-1:0]     c_vld;
  logic [DEPTH-1:0]     c_ge;
  logic [ID_BITS-1:0]   c_id   [DEPTH];
  logic [PRIO_W-1:0]    c_prio [DEPTH];
  logic [DEPTH:0]       seen;
  logic                 any_hit;
  logic                 full;
  logic                 empty;

  assign accept = start && !pend_q;
  assign busy   = pend_q;

  // only the low ID_BITS bits of the id take part
  assign id_in_ext = {{ID_BITS{1'b0}}, task_id_i};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q     <= func_i;
      req_id_q   <= id_in_ext[ID_BITS-1:0];
      req_prio_q <= priority_req_i;
    end
  end

  // row of slots; seen ripples from the front towards the back
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               l_ge, l_vld, r_vld;
    logic [ID_BITS-1:0] l_id, r_id;
    logic [PRIO_W-1:0]  l_prio, r_prio;

    if (i == 0) begin : g_front
      assign l_ge   = 1'b0;
      assign l_vld  = 1'b0;
      assign l_id   = '0;
      assign l_prio = '0;
    end else begin : g_mid_l
      assign l_ge   = c_ge[i-1];
      assign l_vld  = c_vld[i-1];
      assign l_id   = c_id[i-1];
      assign l_prio = c_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign r_vld  = 1'b0;
      assign r_id   = '0;
      assign r_prio = '0;
    end else begin : g_mid_r
      assign r_vld  = c_vld[i+1];
      assign r_id   = c_id[i+1];
      assign r_prio = c_prio[i+1];
    end

    potq_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .req_id_i     (req_id_q),
      .left_ge_i    (l_ge),
      .left_vld_i   (l_vld),
      .left_id_i    (l_id),
      .left_prio_i  (l_prio),
      .right_vld_i  (r_vld),
      .right_id_i   (r_id),
      .right_prio_i (r_prio),
      .seen_i       (seen[i]),
      .vld_o        (c_vld[i]),
      .id_o         (c_id[i]),
      .prio_o       (c_prio[i]),
      .ge_o         (c_ge[i]),
      .seen_o       (seen[i+1])
    );
  end

  // ids are unique, so at most one slot matches
  assign any_hit = seen[DEPTH];
  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);

  // decide the action and the result of the pending request
  always_comb begin
    act      = ACT_NONE;
    status_d = ST_OK;
    oid_d    = '0;
    oprio_d  = '0;
    count_d  = count_q;
    id_out_ext = {{TID_W{1'b0}}, c_id[0]};
    unique case (func_q)
      FN_ENQ: begin
        // full wins over an id already queued
        if (full) begin
          status_d = ST_FULL;
        end else if (!any_hit) begin
          act     = ACT_INS;
          count_d = count_q + CNT_W'(1);
        end
      end
      FN_REM: begin
        if (any_hit) begin
          act     = ACT_DEL;
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      FN_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          act     = ACT_POP;
          count_d = count_q - CNT_W'(1);
          oid_d   = id_out_ext[TID_W-1:0];
          oprio_d = c_prio[0];
        end
      end
      default: begin
        // unused code: no change, plain ok
      end
    endcase
  end

  // cells move only in the cycle after a request is taken
  assign ctrl.act  = pend_q ? act : ACT_NONE;
  assign ctrl.prio = req_prio_q;

  // occupancy wraps at 32, as the field is five bits wide
  assign count_ext = {{OCC_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      pend_q <= accept;
      done_q <= pend_q;
      if (pend_q) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      status_q <= status_d;
      oid_q    <= oid_d;
      oprio_q  <= oprio_d;
      occ_q    <= count_ext[OCC_W-1:0];
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_task_id_o  = oid_q;
  assign out_priority_o = oprio_q;
  assign occupancy_o    = occ_q;

`ifndef SYNTHESIS
  // occupied slots always match the entry count
  a_count_matches_slots : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(c_vld) == count_q)
    else $error("slot valid bits disagree with entry count");

  // occupied slots sit at the front of the row
  a_slots_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((c_vld + DEPTH'(1)) & c_vld) == '0)
    else $error("gap in occupied slots");

  // every taken request gives a result strobe, with done_o registered from busy
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("result strobe missing");

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a request");
`endif

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the priority ordered task queue: a scoreboard
// class keeps its own sorted copy of the queue, works out the outcome of
// each accepted request and compares every result strobe field by field
// ----------------------------------------------------------------------------

module tb_top;
  import potq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // request code with no operation behind it, answered with an unchanged queue
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
  localparam logic [TID_W-1:0]  ID_MASK  = TID_W'((1 << ID_BITS_DEF) - 1);

  // bias of one burst of random requests
  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    tid;
    logic [PRIO_W-1:0]   prio;
    logic [OCC_W-1:0]    occ;
  } outcome_t;

  // sorted shadow queue plus the outcomes still owed by the block
  class task_queue_scoreboard;
    logic [TID_W-1:0]  slot_id   [QUEUE_DEPTH];
    logic [PRIO_W-1:0] slot_prio [QUEUE_DEPTH];
    int                count;
    outcome_t          expected_q[$];
    int unsigned       errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int find_slot(logic [TID_W-1:0] id);
      for (int i = 0; i < count; i++) begin
        if (slot_id[i] == id) return i;
      end
      return -1;
    endfunction

    // close the gap left by the entry at pos
    function void remove_at(int pos);
      for (int i = pos; i + 1 < count; i++) begin
        slot_id[i]   = slot_id[i + 1];
        slot_prio[i] = slot_prio[i + 1];
      end
      count--;
    endfunction

    function logic [TID_W-1:0] pick_queued_id();
      return slot_id[$urandom_range(0, count - 1)];
    endfunction

    function void note_request(logic [FUNC_W-1:0] f, logic [TID_W-1:0] id,
                               logic [PRIO_W-1:0] prio);
      outcome_t         res;
      int               pos;
      logic [TID_W-1:0] idm;
      idm        = id & ID_MASK;
      res        = '0;
      res.status = ST_OK;
      case (f)
        FN_ENQ: begin
          // full wins over an id already present
          if (count >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
          end else if (find_slot(idm) < 0) begin
            // goes before the first strictly greater priority, ties keep arrival order
            pos = count;
            for (int i = 0; i < count; i++) begin
              if (slot_prio[i] > prio) begin
                pos = i;
                break;
              end
            end
            for (int i = count; i > pos; i--) begin
              slot_id[i]   = slot_id[i - 1];
              slot_prio[i] = slot_prio[i - 1];
            end
            slot_id[pos]   = idm;
            slot_prio[pos] = prio;
            count++;
          end
        end
        FN_REM: begin
          pos = find_slot(idm);
          if (pos < 0) res.status = ST_NOT_FOUND;
          else remove_at(pos);
        end
        FN_POP: begin
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.tid  = slot_id[0];
            res.prio = slot_prio[0];
            remove_at(0);
          end
        end
        default: ;
      endcase
      res.occ = OCC_W'(count);
      expected_q.push_back(res);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: status %0d id %0d prio %0d occ %0d",
               got.status, got.tid, got.prio, got.occ);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.tid !== want.tid) begin
        $error("out_task_id mismatch: expected %0d, actual %0d", want.tid, got.tid);
        errors++;
      end
      if (got.prio !== want.prio) begin
        $error("out_priority mismatch: expected %0d, actual %0d", want.prio, got.prio);
        errors++;
      end
      if (got.occ !== want.occ) begin
        $error("occupancy mismatch: expected %0d, actual %0d", want.occ, got.occ);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic [FUNC_W-1:0]   func_i         = FN_ENQ;
  logic [TID_W-1:0]    task_id_i      = '0;
  logic [PRIO_W-1:0]   priority_req_i = '0;
  logic                busy;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [TID_W-1:0]    out_task_id_o;
  logic [PRIO_W-1:0]   out_priority_o;
  logic [OCC_W-1:0]    occupancy_o;

  task_queue_scoreboard sb;
  outcome_t             seen;
  bit                   idle_on = 1'b1;
  int unsigned          cycles  = 0;

  priority_ordered_task_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .task_id_i      (task_id_i),
    .priority_req_i (priority_req_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_task_id_o  (out_task_id_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog, far beyond the slowest legal run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // results cannot be held off, so every strobe is taken as it comes
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      seen.status = status_o;
      seen.tid    = out_task_id_o;
      seen.prio   = out_priority_o;
      seen.occ    = occupancy_o;
      sb.check_result(seen);
    end
  end

  // one request: optional random gap, then hold start until an edge with busy low
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [TID_W-1:0] id,
                              input logic [PRIO_W-1:0] prio);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // start stays high straight into the next request when there is no gap
    start          <= 1'b1;
    func_i         <= f;
    task_id_i      <= id;
    priority_req_i <= prio;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(f, id, prio);
  endtask

  // hold the request side off until every owed result has come back
  task automatic wait_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  // bursts biased towards filling, draining or a mix, so full and empty are both hit often
  task automatic run_random_traffic();
    int unsigned       issued;
    int unsigned       len;
    int unsigned       r;
    traffic_e          mode;
    logic [FUNC_W-1:0] f;
    logic [TID_W-1:0]  id;
    logic [PRIO_W-1:0] prio;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mode = traffic_e'($urandom_range(0, 2));
      len  = $urandom_range(16, 64);
      repeat (len) begin
        // a long stretch with back to back requests
        idle_on = !(issued >= 500 && issued < 800);
        r = $urandom_range(0, 99);
        case (mode)
          MODE_FILL:  f = (r < 75) ? FN_ENQ : (r < 85) ? FN_REM : (r < 98) ? FN_POP : FN_SPARE;
          MODE_DRAIN: f = (r < 20) ? FN_ENQ : (r < 55) ? FN_REM : (r < 98) ? FN_POP : FN_SPARE;
          default:    f = (r < 40) ? FN_ENQ : (r < 68) ? FN_REM : (r < 98) ? FN_POP : FN_SPARE;
        endcase
        // queued ids for remove hits and duplicate enqueues, a narrow pool for collisions
        r = $urandom_range(0, 99);
        if (sb.count > 0 && ((f == FN_REM && r < 65) || (f == FN_ENQ && r < 10)))
          id = sb.pick_queued_id();
        else if ($urandom_range(0, 99) < 55)
          id = TID_W'($urandom_range(0, 23));
        else
          id = TID_W'($urandom_range(0, 255));
        // a few coarse priorities give ties and the extremes
        if ($urandom_range(0, 99) < 30) prio = PRIO_W'($urandom_range(0, 3) * 85);
        else prio = PRIO_W'($urandom_range(0, 255));
        send_request(f, id, prio);
        if (f != FN_SPARE) issued++;
      end
      if ($urandom_range(0, 4) == 0) wait_until_drained();
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty cases, spare code, extremes, ties, duplicate id, removes
    send_request(FN_POP,   8'h00, 8'h00);
    send_request(FN_REM,   8'h00, 8'h00);
    send_request(FN_SPARE, 8'hff, 8'hff);
    send_request(FN_ENQ,   8'h00, 8'hff);
    send_request(FN_ENQ,   8'hff, 8'h00);
    send_request(FN_ENQ,   8'h5a, 8'h80);
    send_request(FN_ENQ,   8'ha5, 8'h80);
    send_request(FN_ENQ,   8'h5a, 8'h01);
    send_request(FN_ENQ,   8'h3c, 8'h80);
    send_request(FN_SPARE, 8'h00, 8'h00);
    send_request(FN_REM,   8'ha5, 8'h00);
    send_request(FN_REM,   8'h33, 8'h00);
    send_request(FN_POP,   8'h77, 8'h00);
    send_request(FN_POP,   8'h00, 8'h00);
    send_request(FN_POP,   8'h00, 8'h00);
    send_request(FN_POP,   8'h00, 8'h00);
    send_request(FN_POP,   8'h00, 8'h00);
    send_request(FN_REM,   8'hff, 8'h00);
    wait_until_drained();

    run_random_traffic();
    wait_until_drained();
    // room for a stray strobe after the last one owed
    repeat (6) @(posedge clk_i);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
